/* rtl/jlaw_pkg.sv */
// ----------------------------------------------------------------------------
// jlaw_pkg
// Shared widths, constants and types of the joint limit avoidance weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package jlaw_pkg;

  localparam int unsigned MaxJointsDef = 16;

  // Numerator D^2 |S| 2^30 and denominator P^2 Q^2 of the gradient.
  localparam int unsigned NumW     = 127;
  localparam int unsigned DenW     = 128;
  localparam int unsigned CmpW     = 160;
  localparam int unsigned GradBits = 31;

  // Weight stage: 2^48 divided by (65536 + |G|), then a square root.
  localparam int unsigned WRemW  = 49;
  localparam int unsigned WCmpW  = 66;
  localparam int unsigned WQuotW = 33;
  localparam int unsigned SqRemW = 36;
  localparam int unsigned RootW  = 17;

  localparam logic [31:0]     GradPosMag = 32'h7FFF_FFFF;
  localparam logic [31:0]     GradNegMag = 32'h8000_0000;
  localparam logic [16:0]     WeightOne  = 17'd65536;
  localparam logic [WRemW-1:0] WDividend = WRemW'(1) << 48;

  // Control that travels with an item through the gradient stages.
  typedef struct packed {
    logic       vld;
    logic [3:0] idx;
    logic       neg;
    logic       lmt;
    logic       sat;
  } jlaw_tag_t;

  // Control that travels with an item through the weight stages.
  typedef struct packed {
    logic        vld;
    logic        keep_one;
    logic        sat;
    logic [31:0] gbits;
  } jlaw_wtag_t;

endpackage

`default_nettype wire

/* rtl/jlaw_in_if.sv */
// ----------------------------------------------------------------------------
// jlaw_in_if
// Input channel: one joint's index, angle and limits.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlaw_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         joint_index;
  logic signed [31:0] joint_angle;
  logic signed [31:0] limit_low;
  logic signed [31:0] limit_high;

  modport source (output valid, output joint_index, output joint_angle,
                  output limit_low, output limit_high, input ready);
  modport sink   (input valid, input joint_index, input joint_angle,
                  input limit_low, input limit_high, output ready);
endinterface

`default_nettype wire

/* rtl/jlaw_out_if.sv */
// ----------------------------------------------------------------------------
// jlaw_out_if
// Result channel: weight, gradient and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlaw_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        weight;
  logic signed [31:0] gradient_out;
  logic               saturated;

  modport source (output valid, output weight, output gradient_out,
                  output saturated, input ready);
  modport sink   (input valid, input weight, input gradient_out,
                  input saturated, output ready);
endinterface

`default_nettype wire

/* rtl/jlaw_ram.sv */
// ----------------------------------------------------------------------------
// jlaw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module jlaw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/jlaw_front.sv */
// ----------------------------------------------------------------------------
// jlaw_front
// Five stages: differences, products and the overflow check of the gradient.
// ----------------------------------------------------------------------------
`default_nettype none

module jlaw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  logic [3:0]                    idx_i,
  input  logic signed [31:0]            angle_i,
  input  logic signed [31:0]            low_i,
  input  logic signed [31:0]            high_i,
  output jlaw_pkg::jlaw_tag_t           tag_o,
  output logic [jlaw_pkg::NumW-1:0]     num_o,
  output logic [jlaw_pkg::DenW-1:0]     den_o
);
  import jlaw_pkg::*;

  function automatic logic [34:0] mag35(input logic signed [34:0] v);
    mag35 = v[34] ? 35'(-v) : 35'(v);
  endfunction

  logic signed [34:0] a_x, l_x, h_x, d_w, s_w, p_w, q_w;
  logic [34:0]        dm_w, sm_w, pm_w, qm_w;

  jlaw_tag_t   tag_a_q, tag_b_q, tag_c_q, tag_d_q, tag_e_q;
  jlaw_tag_t   tag_e_d;
  logic [32:0] dm_a_q, pm_a_q, qm_a_q;
  logic [33:0] sm_a_q, sm_b_q;
  logic [65:0] d2_b_q, pq_b_q;
  logic [66:0] nl_c_q, nh_c_q;
  logic [65:0] ll_c_q, lh_c_q, hh_c_q;
  logic [NumW-1:0] num_d_q, num_e_q;
  logic [DenW-1:0] den_d_q, den_e_q;
  logic            ovf_w;

  always_comb begin
    a_x  = {{3{angle_i[31]}}, angle_i};
    l_x  = {{3{low_i[31]}}, low_i};
    h_x  = {{3{high_i[31]}}, high_i};
    d_w  = h_x - l_x;
    s_w  = (a_x <<< 1) - h_x - l_x;
    p_w  = h_x - a_x;
    q_w  = a_x - l_x;
    dm_w = mag35(d_w);
    sm_w = mag35(s_w);
    pm_w = mag35(p_w);
    qm_w = mag35(q_w);
  end

  // A zero divisor makes the denominator zero, so it saturates here as well.
  assign ovf_w = ({33'b0, num_d_q} >= (CmpW'(den_d_q) << GradBits));

  always_comb begin
    tag_e_d     = tag_d_q;
    tag_e_d.sat = !tag_d_q.lmt && ovf_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
      tag_d_q <= '0;
      tag_e_q <= '0;
    end else if (adv_i) begin
      tag_a_q.vld <= vld_i;
      tag_a_q.idx <= idx_i;
      tag_a_q.neg <= s_w[34];
      tag_a_q.lmt <= (low_i == 32'sd0) && (high_i == 32'sd0);
      tag_a_q.sat <= 1'b0;
      tag_b_q     <= tag_a_q;
      tag_c_q     <= tag_b_q;
      tag_d_q     <= tag_c_q;
      tag_e_q     <= tag_e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dm_a_q  <= dm_w[32:0];
      sm_a_q  <= sm_w[33:0];
      pm_a_q  <= pm_w[32:0];
      qm_a_q  <= qm_w[32:0];
      d2_b_q  <= dm_a_q * dm_a_q;
      pq_b_q  <= pm_a_q * qm_a_q;
      sm_b_q  <= sm_a_q;
      nl_c_q  <= d2_b_q[32:0] * sm_b_q;
      nh_c_q  <= d2_b_q[65:33] * sm_b_q;
      ll_c_q  <= pq_b_q[32:0] * pq_b_q[32:0];
      lh_c_q  <= pq_b_q[32:0] * pq_b_q[65:33];
      hh_c_q  <= pq_b_q[65:33] * pq_b_q[65:33];
      num_d_q <= (NumW'(nh_c_q) << 63) + (NumW'(nl_c_q) << 30);
      den_d_q <= (DenW'(hh_c_q) << 66) + (DenW'(lh_c_q) << 34) + DenW'(ll_c_q);
      num_e_q <= num_d_q;
      den_e_q <= den_d_q;
    end
  end

  assign tag_o = tag_e_q;
  assign num_o = num_e_q;
  assign den_o = den_e_q;

endmodule

`default_nettype wire

/* rtl/jlaw_div.sv */
// ----------------------------------------------------------------------------
// jlaw_div
// Restoring divider for the gradient magnitude, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jlaw_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  jlaw_pkg::jlaw_tag_t               tag_i,
  input  logic [jlaw_pkg::NumW-1:0]         num_i,
  input  logic [jlaw_pkg::DenW-1:0]         den_i,
  output jlaw_pkg::jlaw_tag_t               tag_o,
  output logic [jlaw_pkg::GradBits-1:0]     quot_o
);
  import jlaw_pkg::*;

  jlaw_tag_t             tag_q  [GradBits];
  logic [NumW-1:0]       rem_q  [GradBits];
  logic [DenW-1:0]       den_q  [GradBits];
  logic [GradBits-1:0]   quot_q [GradBits];

  for (genvar j = 0; j < GradBits; j++) begin : g_stage
    localparam int unsigned K = GradBits - 1 - j;
    jlaw_tag_t           tag_in;
    logic [NumW-1:0]     rem_in;
    logic [DenW-1:0]     den_in;
    logic [GradBits-1:0] quot_in;
    logic [CmpW-1:0]     trial;
    logic [CmpW-1:0]     diff;
    logic                ge;

    if (j == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign tag_in  = tag_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
    end

    assign trial = CmpW'(den_in) << K;
    assign ge    = (CmpW'(rem_in) >= trial);
    assign diff  = CmpW'(rem_in) - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j] <= '0;
      end else if (adv_i) begin
        tag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        den_q[j] <= den_in;
        if (ge) begin
          rem_q[j]  <= diff[NumW-1:0];
          quot_q[j] <= quot_in | (GradBits'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          quot_q[j] <= quot_in;
        end
      end
    end
  end

  assign tag_o  = tag_q[GradBits-1];
  assign quot_o = quot_q[GradBits-1];

endmodule

`default_nettype wire

/* rtl/jlaw_store.sv */
// ----------------------------------------------------------------------------
// jlaw_store
// Per-joint store of the last gradient magnitude, with write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module jlaw_store #(
  parameter int unsigned MAX_JOINTS = jlaw_pkg::MaxJointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [3:0]  rd_idx_i,
  input  logic        wr_vld_i,
  input  logic [3:0]  wr_idx_i,
  input  logic [31:0] wr_mag_i,
  output logic [31:0] prev_mag_o
);
  import jlaw_pkg::*;

  localparam int unsigned AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [AW+3:0]         rd_ext, wr_ext;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  rd_inr, wr_inr, wr_en;
  logic [MAX_JOINTS-1:0] written_q;
  logic                  hit_q, vb_q, inr_q;
  logic [31:0]           fwd_q, ram_rdata;

  assign rd_ext  = {{AW{1'b0}}, rd_idx_i};
  assign wr_ext  = {{AW{1'b0}}, wr_idx_i};
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr_ext[AW-1:0];
  assign rd_inr  = ({28'b0, rd_idx_i} < 32'(MAX_JOINTS));
  assign wr_inr  = ({28'b0, wr_idx_i} < 32'(MAX_JOINTS));
  assign wr_en   = adv_i && wr_vld_i && wr_inr;

  jlaw_ram #(
    .WIDTH (32),
    .DEPTH (MAX_JOINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_mag_i),
    .re_i    (adv_i),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      hit_q     <= 1'b0;
      vb_q      <= 1'b0;
      inr_q     <= 1'b0;
    end else if (adv_i) begin
      if (wr_en) begin
        written_q[wr_addr] <= 1'b1;
      end
      // The item being read follows the one written in the same cycle.
      hit_q <= wr_en && (wr_addr == rd_addr) && rd_inr;
      vb_q  <= rd_inr && written_q[rd_addr];
      inr_q <= rd_inr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_q <= wr_mag_i;
    end
  end

  always_comb begin
    if (!inr_q) begin
      prev_mag_o = '0;
    end else if (hit_q) begin
      prev_mag_o = fwd_q;
    end else if (vb_q) begin
      prev_mag_o = ram_rdata;
    end else begin
      prev_mag_o = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/jlaw_weight.sv */
// ----------------------------------------------------------------------------
// jlaw_weight
// Weight 1/sqrt(1+|g|) in Q1.16: a pipelined divide of 2^48, then a
// pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jlaw_weight (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  jlaw_pkg::jlaw_wtag_t wtag_i,
  input  logic [31:0]          gmag_i,
  output jlaw_pkg::jlaw_wtag_t wtag_o,
  output logic [16:0]          weight_o
);
  import jlaw_pkg::*;

  jlaw_wtag_t        dtag_q [WQuotW];
  logic [WRemW-1:0]  drem_q [WQuotW];
  logic [WQuotW-1:0] ddv_q  [WQuotW];
  logic [WQuotW-1:0] dquo_q [WQuotW];

  jlaw_wtag_t        stag_q  [RootW];
  logic [SqRemW-1:0] srem_q  [RootW];
  logic [RootW-1:0]  sroot_q [RootW];

  logic [WQuotW-1:0] divisor_w;

  assign divisor_w = WQuotW'(gmag_i) + WQuotW'(17'd65536);

  for (genvar j = 0; j < WQuotW; j++) begin : g_div
    localparam int unsigned K = WQuotW - 1 - j;
    jlaw_wtag_t        tag_in;
    logic [WRemW-1:0]  rem_in;
    logic [WQuotW-1:0] dv_in, quo_in;
    logic [WCmpW-1:0]  trial, diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign tag_in = wtag_i;
      assign rem_in = WDividend;
      assign dv_in  = divisor_w;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = dtag_q[j-1];
      assign rem_in = drem_q[j-1];
      assign dv_in  = ddv_q[j-1];
      assign quo_in = dquo_q[j-1];
    end

    assign trial = WCmpW'(dv_in) << K;
    assign ge    = (WCmpW'(rem_in) >= trial);
    assign diff  = WCmpW'(rem_in) - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dtag_q[j] <= '0;
      end else if (adv_i) begin
        dtag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ddv_q[j] <= dv_in;
        if (ge) begin
          drem_q[j] <= diff[WRemW-1:0];
          dquo_q[j] <= quo_in | (WQuotW'(1) << K);
        end else begin
          drem_q[j] <= rem_in;
          dquo_q[j] <= quo_in;
        end
      end
    end
  end

  // Root built from the top bit down; the remainder holds x - root^2.
  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    localparam int unsigned B = RootW - 1 - j;
    jlaw_wtag_t        tag_in;
    logic [SqRemW-1:0] rem_in, term;
    logic [RootW-1:0]  root_in;

    if (j == 0) begin : g_first
      assign tag_in  = dtag_q[WQuotW-1];
      assign rem_in  = SqRemW'(dquo_q[WQuotW-1]);
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = stag_q[j-1];
      assign rem_in  = srem_q[j-1];
      assign root_in = sroot_q[j-1];
    end

    assign term = (SqRemW'(root_in) << (B + 1)) + (SqRemW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stag_q[j] <= '0;
      end else if (adv_i) begin
        stag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (rem_in >= term) begin
          srem_q[j]  <= rem_in - term;
          sroot_q[j] <= root_in | (RootW'(1) << B);
        end else begin
          srem_q[j]  <= rem_in;
          sroot_q[j] <= root_in;
        end
      end
    end
  end

  assign wtag_o   = stag_q[RootW-1];
  assign weight_o = stag_q[RootW-1].keep_one ? WeightOne : sroot_q[RootW-1];

endmodule

`default_nettype wire

/* rtl/joint_limit_avoidance_weight.sv */
// ----------------------------------------------------------------------------
// joint_limit_avoidance_weight
// Per-joint limit avoidance gradient and weight, fully pipelined.
//
//   Port   Dir  Handshake    Carries
//   in_i   in   valid/ready  joint_index, joint_angle, limit_low, limit_high
//   out_o  out  valid/ready  weight, gradient_out, saturated
//
// One transaction enters per cycle unless stalled; there are 5 front stages,
// 31 gradient divider stages, 1 store stage, 33 weight divider stages and
// 17 square root stages. The per-joint store is read and written in the
// store stage with a forwarding register, so equal indexes may follow back
// to back. Reset clears all valid bits and the store's written flags.
// When the result is not taken the whole pipeline holds in place.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_limit_avoidance_weight #(
  parameter int unsigned MAX_JOINTS = jlaw_pkg::MaxJointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jlaw_in_if.sink     in_i,
  jlaw_out_if.source  out_o
);
  import jlaw_pkg::*;

  logic                adv;
  jlaw_tag_t           f_tag, d_tag;
  logic [NumW-1:0]     f_num;
  logic [DenW-1:0]     f_den;
  logic [GradBits-1:0] d_quot;
  logic [31:0]         gmag_w, gbits_w;

  jlaw_tag_t           r_tag_q;
  logic [31:0]         r_gmag_q, r_gbits_q;
  logic [31:0]         prev_mag;
  jlaw_wtag_t          w_in, w_out;
  logic [16:0]         w_weight;

  assign adv      = !w_out.vld || out_o.ready;
  assign in_i.ready = adv;

  jlaw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (in_i.valid),
    .idx_i   (in_i.joint_index),
    .angle_i (in_i.joint_angle),
    .low_i   (in_i.limit_low),
    .high_i  (in_i.limit_high),
    .tag_o   (f_tag),
    .num_o   (f_num),
    .den_o   (f_den)
  );

  jlaw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tag_i  (f_tag),
    .num_i  (f_num),
    .den_i  (f_den),
    .tag_o  (d_tag),
    .quot_o (d_quot)
  );

  always_comb begin
    if (d_tag.lmt) begin
      gmag_w = '0;
    end else if (d_tag.sat) begin
      gmag_w = d_tag.neg ? GradNegMag : GradPosMag;
    end else begin
      gmag_w = {1'b0, d_quot};
    end
    gbits_w = d_tag.neg ? 32'(-gmag_w) : gmag_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_tag_q <= '0;
    end else if (adv) begin
      r_tag_q <= d_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_gmag_q  <= gmag_w;
      r_gbits_q <= gbits_w;
    end
  end

  jlaw_store #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .rd_idx_i   (d_tag.idx),
    .wr_vld_i   (r_tag_q.vld),
    .wr_idx_i   (r_tag_q.idx),
    .wr_mag_i   (r_gmag_q),
    .prev_mag_o (prev_mag)
  );

  // A smaller gradient than last time leaves the weight at one.
  always_comb begin
    w_in.vld      = r_tag_q.vld;
    w_in.keep_one = r_tag_q.lmt || (r_gmag_q < prev_mag);
    w_in.sat      = r_tag_q.sat;
    w_in.gbits    = r_gbits_q;
  end

  jlaw_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .wtag_i   (w_in),
    .gmag_i   (r_gmag_q),
    .wtag_o   (w_out),
    .weight_o (w_weight)
  );

  assign out_o.valid        = w_out.vld;
  assign out_o.weight       = w_weight;
  assign out_o.gradient_out = w_out.gbits;
  assign out_o.saturated    = w_out.sat;

endmodule

`default_nettype wire
